### hdl/mtg_pkg.sv
// Types and constants shared by the MT19937 generator modules.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS + 2);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ADDR_W:0]   addr_ext_t;
  typedef logic [1:0]        act_t;

  localparam addr_t LAST_WORD    = addr_t'(STATE_WORDS - 1);
  localparam addr_t FULL_POS     = addr_t'(STATE_WORDS);
  localparam addr_t UNSEEDED_POS = addr_t'(STATE_WORDS + 1);

  localparam act_t ACT_DRAW = 2'd0;
  localparam act_t ACT_SEED = 2'd1;
  localparam act_t ACT_LOAD = 2'd2;

  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_write;    // write one state word from the input ports
    logic seed_init;     // load the LCG seed
    logic seed_default;  // seed with the default value, not the register
    logic seed_step;     // write one seeded word, advance the LCG twice
    logic twist_step;    // one step of the regeneration pipeline
    logic cnt_clear;
    logic rd_prime;      // read word 0 ahead of the twist
    logic fetch;         // read the word at the read position, advance it
    logic emit;          // temper the fetched word into the output register
    logic pos_full;      // read position to "seeded, regenerate next"
    logic pos_zero;
  } mtg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic unseeded;
    logic full;
    logic seed_last;
    logic twist_last;
  } mtg_stat_t;

endpackage

### hdl/mtg_ctrl.sv
// Controller state machine of the MT19937 generator.
module mtg_ctrl import mtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  act_t      action,
  input  mtg_stat_t stat,
  output mtg_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEED  = 3'd1;
  localparam logic [2:0] S_TWIST = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;
  logic       draw_pend, draw_pend_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next     = state;
    draw_pend_next = draw_pend;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_DRAW: begin
              if (stat.unseeded) begin
                cmd.seed_init    = 1'b1;
                cmd.seed_default = 1'b1;
                cmd.cnt_clear    = 1'b1;
                draw_pend_next   = 1'b1;
                state_next       = S_SEED;
              end else if (stat.full) begin
                cmd.rd_prime  = 1'b1;
                cmd.cnt_clear = 1'b1;
                state_next    = S_TWIST;
              end else begin
                cmd.fetch  = 1'b1;
                state_next = S_EMIT;
              end
            end
            ACT_SEED: begin
              cmd.seed_init  = 1'b1;
              cmd.cnt_clear  = 1'b1;
              draw_pend_next = 1'b0;
              state_next     = S_SEED;
            end
            ACT_LOAD: cmd.load_write = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        if (stat.seed_last) begin
          cmd.pos_full = 1'b1;
          if (draw_pend) begin
            // straight on into the twist; word 0 is already written
            cmd.rd_prime  = 1'b1;
            cmd.cnt_clear = 1'b1;
            state_next    = S_TWIST;
          end else begin
            state_next = S_IDLE;
          end
          draw_pend_next = 1'b0;
        end
      end
      S_TWIST: begin
        cmd.twist_step = 1'b1;
        if (stat.twist_last) begin
          cmd.pos_zero = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      draw_pend <= 1'b0;
    end else begin
      state     <= state_next;
      draw_pend <= draw_pend_next;
    end
  end

endmodule

### hdl/mtg_datapath.sv
// Datapath of the MT19937 generator: state memory, seeding LCG, twist and tempering.
module mtg_datapath import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mtg_cmd_t    cmd,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  addr_t       word_index,
  input  logic [31:0] word_value,
  output mtg_stat_t   stat,
  output logic [31:0] random_word,
  output logic        result_valid
);

  localparam logic [31:0] LCG_MULT     = 32'd69069;
  localparam logic [31:0] LCG_MULT2    = 32'(64'(LCG_MULT) * 64'(LCG_MULT));
  localparam logic [31:0] LCG_ADD2     = LCG_MULT + 32'd1;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;

  function automatic logic [31:0] mix(input logic [31:0] upper, input logic [31:0] lower,
                                      input logic [31:0] far_word);
    logic [31:0] y;
    logic [31:0] r;
    y = {upper[31], lower[30:0]};
    r = far_word ^ {1'b0, y[31:1]};
    if (y[0]) r = r ^ TWIST_MATRIX;
    return r;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [31:0] mem [0:STATE_WORDS-1];
  logic [31:0] rd_a, rd_b;
  logic [31:0] upper;
  logic [31:0] seed_reg;
  logic [31:0] lcg;
  addr_t       cnt;
  addr_t       pos;

  logic [31:0] lcg_one, lcg_two, seed_word;
  addr_ext_t   far_sum;
  addr_t       far_addr, next_addr, addr_a;
  logic        we;
  addr_t       wa;
  logic [31:0] wd;
  logic        load_ok;

  // two LCG steps per word, computed side by side from the same seed
  assign lcg_one   = lcg * LCG_MULT + 32'd1;
  assign lcg_two   = lcg * LCG_MULT2 + LCG_ADD2;
  assign seed_word = {lcg[31:16], lcg_one[31:16]};

  assign far_sum   = addr_ext_t'(cnt) + addr_ext_t'(TWIST_OFFSET);
  assign far_addr  = (far_sum >= addr_ext_t'(STATE_WORDS))
                   ? addr_t'(far_sum - addr_ext_t'(STATE_WORDS)) : far_sum[ADDR_W-1:0];
  assign next_addr = (cnt >= LAST_WORD) ? '0 : cnt + addr_t'(1);

  assign load_ok = cmd.load_write && (word_index < FULL_POS);

  always_comb begin
    if (cmd.twist_step)  addr_a = next_addr;
    else if (cmd.fetch)  addr_a = pos;
    else                 addr_a = '0;
  end

  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = seed_word;
    if (load_ok) begin
      we = 1'b1;
      wa = word_index;
      wd = word_value;
    end else if (cmd.seed_step) begin
      we = 1'b1;
    end else if (cmd.twist_step && (cnt != '0)) begin
      we = 1'b1;
      wa = cnt - addr_t'(1);
      wd = mix(upper, rd_a, rd_b);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[addr_a];
    rd_b <= mem[far_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.twist_step) upper <= rd_a;
    if (cmd.seed_init)
      lcg <= cmd.seed_default ? DEFAULT_SEED : seed_reg;
    else if (cmd.seed_step)
      lcg <= lcg_two;
    if (cmd.emit) random_word <= temper(rd_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg     <= DEFAULT_SEED;
      pos          <= UNSEEDED_POS;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (seed_we) seed_reg <= seed_data;
      if (cmd.cnt_clear)
        cnt <= '0;
      else if (cmd.seed_step || cmd.twist_step)
        cnt <= cnt + addr_t'(1);
      if (cmd.pos_full || (load_ok && word_index == LAST_WORD))
        pos <= FULL_POS;
      else if (cmd.pos_zero)
        pos <= '0;
      else if (cmd.fetch)
        pos <= pos + addr_t'(1);
      result_valid <= cmd.emit;
    end
  end

  assign stat.unseeded   = (pos == UNSEEDED_POS);
  assign stat.full       = (pos == FULL_POS);
  assign stat.seed_last  = (cnt == LAST_WORD);
  assign stat.twist_last = (cnt == FULL_POS);

endmodule

### hdl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: controller plus datapath.
// Draw from a twisted state: fetch, then emit; result strobe rises as busy falls.
// Regenerating draw: the twist pipeline sweeps the 624 words, then a fetch and an emit.
// Seed action: busy while writing one word a cycle; a draw before seeding adds seed and twist.
// Load action: busy stays low. The receiver cannot stall: result_valid lasts 1 cycle.
// Synchronous reset: idle, not seeded, seed register 4357; state memory undefined until written.
module mersenne_twister_generator import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [9:0]  word_index,
  input  logic [31:0] word_value,
  // seed register write port
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  // result side
  output logic        result_valid,
  output logic [31:0] random_word
);

  mtg_cmd_t  cmd;
  mtg_stat_t stat;

  // Sequencer: decodes the accepted item and steps the seed and twist sweeps
  mtg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Memory with two registered read ports, LCG seeding, twist pipeline, tempering
  mtg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_we      (seed_we),
    .seed_data    (seed_data),
    .word_index   (word_index),
    .word_value   (word_value),
    .stat         (stat),
    .random_word  (random_word),
    .result_valid (result_valid)
  );

endmodule
